/* rtl/core/synced_dual_actuator_position_ctrl_assert.svh */
// Assertion macros for the synchronised dual actuator position controller.
`ifndef SYNCED_DUAL_ACTUATOR_POSITION_CTRL_ASSERT_SVH
`define SYNCED_DUAL_ACTUATOR_POSITION_CTRL_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SDAPC_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SDAPC_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

/* rtl/core/sdapc_pkg.sv */
// Shared types and constants of the synchronised dual actuator position controller.
`timescale 1ns / 1ps
`default_nettype none

package sdapc_pkg;

	localparam int POS_WIDTH  = 16;
	localparam int TICK_WIDTH = 16;

	localparam int TGT_W      = 16;
	localparam int DUTY_W     = 15;
	localparam int GAIN_W     = 12;
	localparam int TIMEOUT_W  = 16;
	localparam int OUT_W      = 16;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int EXT_W      = ((POS_WIDTH > TGT_W) ? POS_WIDTH : TGT_W) + 1;
	localparam int MAG_W      = EXT_W - 1;
	localparam int PROD_W     = MAG_W + GAIN_W;
	localparam int PROP_SHIFT = 6;
	localparam int PROP_W     = PROD_W - PROP_SHIFT;
	localparam int SYNC_FRAC  = 20;
	localparam int FACT_W     = SYNC_FRAC + 1;
	localparam int SLOW_W     = DUTY_W + FACT_W;
	localparam int CNT_W      = (TICK_WIDTH > TIMEOUT_W) ? TICK_WIDTH : TIMEOUT_W;

	localparam logic signed [TGT_W-1:0] TARGET_POS_RST    = TGT_W'(0);
	localparam logic [DUTY_W-1:0]       MAX_DUTY_RST      = DUTY_W'(14746);
	localparam logic [DUTY_W-1:0]       MIN_DUTY_RST      = DUTY_W'(1966);
	localparam logic [GAIN_W-1:0]       APPROACH_GAIN_RST = GAIN_W'(768);
	localparam logic [GAIN_W-1:0]       SYNC_GAIN_RST     = GAIN_W'(333);
	localparam logic [DUTY_W-1:0]       TOLERANCE_RST     = DUTY_W'(492);
	localparam logic [DUTY_W-1:0]       DEADBAND_RST      = DUTY_W'(328);
	localparam logic [TIMEOUT_W-1:0]    TIMEOUT_TICKS_RST = TIMEOUT_W'(1000);

	typedef enum logic [STATUS_W-1:0] {
		ST_MOVING  = 3'd0,
		ST_REACHED = 3'd1,
		ST_TIMEOUT = 3'd2,
		ST_CANCEL  = 3'd3,
		ST_IDLE    = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET_POS    = 3'd0,
		CFG_MAX_DUTY      = 3'd1,
		CFG_MIN_DUTY      = 3'd2,
		CFG_APPROACH_GAIN = 3'd3,
		CFG_SYNC_GAIN     = 3'd4,
		CFG_TOLERANCE     = 3'd5,
		CFG_DEADBAND      = 3'd6,
		CFG_TIMEOUT_TICKS = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [TGT_W-1:0] target_pos;
		logic [DUTY_W-1:0]       max_duty;
		logic [DUTY_W-1:0]       min_duty;
		logic [GAIN_W-1:0]       approach_gain;
		logic [GAIN_W-1:0]       sync_gain;
		logic [DUTY_W-1:0]       tolerance;
		logic [DUTY_W-1:0]       deadband;
		logic [TIMEOUT_W-1:0]    timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic load_s1;
		logic step_s2;
		logic step_s3;
		logic commit;
	} ctrl_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/sdapc_cfg_regs.sv */
// Configuration register file of the position controller.
`timescale 1ns / 1ps
`default_nettype none

module sdapc_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [sdapc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sdapc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output sdapc_pkg::cfg_t                     cfg
);
	import sdapc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_pos    <= TARGET_POS_RST;
			cfg_q.max_duty      <= MAX_DUTY_RST;
			cfg_q.min_duty      <= MIN_DUTY_RST;
			cfg_q.approach_gain <= APPROACH_GAIN_RST;
			cfg_q.sync_gain     <= SYNC_GAIN_RST;
			cfg_q.tolerance     <= TOLERANCE_RST;
			cfg_q.deadband      <= DEADBAND_RST;
			cfg_q.timeout_ticks <= TIMEOUT_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TARGET_POS:    cfg_q.target_pos    <= TGT_W'(cfg_data);
				CFG_MAX_DUTY:      cfg_q.max_duty      <= cfg_data[DUTY_W-1:0];
				CFG_MIN_DUTY:      cfg_q.min_duty      <= cfg_data[DUTY_W-1:0];
				CFG_APPROACH_GAIN: cfg_q.approach_gain <= cfg_data[GAIN_W-1:0];
				CFG_SYNC_GAIN:     cfg_q.sync_gain     <= cfg_data[GAIN_W-1:0];
				CFG_TOLERANCE:     cfg_q.tolerance     <= cfg_data[DUTY_W-1:0];
				CFG_DEADBAND:      cfg_q.deadband      <= cfg_data[DUTY_W-1:0];
				CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data[TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/core/sdapc_ctrl.sv */
// Sequencing state machine of the position controller.
`timescale 1ns / 1ps
`default_nettype none

module sdapc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	output sdapc_pkg::ctrl_cmd_t  cmd
);
	import sdapc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_MULT   = 4'b0010,
		S_SCALE  = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_s1 = 1'b1;
					state_d     = S_MULT;
				end
			end
			S_MULT: begin
				cmd.step_s2 = 1'b1;
				state_d     = S_SCALE;
			end
			S_SCALE: begin
				cmd.step_s3 = 1'b1;
				state_d     = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* rtl/core/sdapc_datapath.sv */
// Datapath of the position controller: errors, products, clamps and move state.
`timescale 1ns / 1ps
`default_nettype none

module sdapc_datapath (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  sdapc_pkg::cfg_t                           cfg,
	input  sdapc_pkg::ctrl_cmd_t                      cmd,
	input  logic signed [sdapc_pkg::POS_WIDTH-1:0]    left_pos,
	input  logic signed [sdapc_pkg::POS_WIDTH-1:0]    right_pos,
	input  logic                                      cancel,
	input  logic                                      start_req,
	output logic signed [sdapc_pkg::OUT_W-1:0]        left_duty,
	output logic signed [sdapc_pkg::OUT_W-1:0]        right_duty,
	output logic [sdapc_pkg::STATUS_W-1:0]            status
);
	import sdapc_pkg::*;

	localparam logic [PROD_W-1:0] SYNC_ONE = PROD_W'(1) << SYNC_FRAC;

	function automatic logic [DUTY_W-1:0] clamp_duty(
		input logic [PROP_W-1:0] v,
		input logic [DUTY_W-1:0] lo,
		input logic [DUTY_W-1:0] hi
	);
		if (v < PROP_W'(lo)) begin
			return lo;
		end else if (v > PROP_W'(hi)) begin
			return hi;
		end else begin
			return v[DUTY_W-1:0];
		end
	endfunction

	// Move state.
	logic [TICK_WIDTH-1:0] tick_q;
	logic                  active_q;

	// First step: differences and magnitudes.
	logic signed [EXT_W-1:0] lp_x, rp_x, tg_x;
	logic signed [EXT_W-1:0] lerr, rerr, gap;
	logic [MAG_W-1:0]        lmag, rmag, agap;
	logic [TICK_WIDTH-1:0]   tick_base;
	logic                    eff_active;
	logic                    timed_out;
	status_t                 pre_st;

	logic [MAG_W-1:0]      lmag_s1, rmag_s1, agap_s1;
	logic                  gap_pos_s1, up_s1;
	status_t               st_s1;
	logic [TICK_WIDTH-1:0] tick_s1;

	assign lp_x = EXT_W'(left_pos);
	assign rp_x = EXT_W'(right_pos);
	assign tg_x = EXT_W'(cfg.target_pos);
	assign lerr = lp_x - tg_x;
	assign rerr = rp_x - tg_x;
	assign gap  = rp_x - lp_x;
	assign lmag = lerr[EXT_W-1] ? MAG_W'(-lerr) : MAG_W'(lerr);
	assign rmag = rerr[EXT_W-1] ? MAG_W'(-rerr) : MAG_W'(rerr);
	assign agap = gap[EXT_W-1] ? MAG_W'(-gap) : MAG_W'(gap);

	assign eff_active = start_req || active_q;
	assign tick_base  = start_req ? '0 : tick_q;
	assign timed_out  = CNT_W'(tick_base) >= CNT_W'(cfg.timeout_ticks);

	always_comb begin
		if (!eff_active) begin
			pre_st = ST_IDLE;
		end else if (cancel) begin
			pre_st = ST_CANCEL;
		end else if (timed_out) begin
			pre_st = ST_TIMEOUT;
		end else begin
			pre_st = ST_MOVING;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_s1) begin
			lmag_s1    <= lmag;
			rmag_s1    <= rmag;
			agap_s1    <= agap;
			gap_pos_s1 <= (gap != '0) && !gap[EXT_W-1];
			up_s1      <= tg_x > lp_x;
			st_s1      <= pre_st;
			tick_s1    <= tick_base;
		end
	end

	// Second step: the three gain products and the tolerance tests.
	logic [PROD_W-1:0]     lprod_s2, rprod_s2, corr_s2;
	logic                  ldone_s2, rdone_s2, sync_s2, gap_pos_s2, up_s2;
	status_t               st_s2;
	logic [TICK_WIDTH-1:0] tick_s2;
	logic                  ldone, rdone;

	assign ldone = lmag_s1 <= MAG_W'(cfg.tolerance);
	assign rdone = rmag_s1 <= MAG_W'(cfg.tolerance);

	always_ff @(posedge clk) begin
		if (cmd.step_s2) begin
			lprod_s2   <= PROD_W'(lmag_s1) * PROD_W'(cfg.approach_gain);
			rprod_s2   <= PROD_W'(rmag_s1) * PROD_W'(cfg.approach_gain);
			corr_s2    <= PROD_W'(agap_s1) * PROD_W'(cfg.sync_gain);
			ldone_s2   <= ldone;
			rdone_s2   <= rdone;
			sync_s2    <= agap_s1 > MAG_W'(cfg.deadband);
			gap_pos_s2 <= gap_pos_s1;
			up_s2      <= up_s1;
			st_s2      <= (st_s1 == ST_MOVING && ldone && rdone) ? ST_REACHED : st_s1;
			tick_s2    <= tick_s1;
		end
	end

	// Third step: clamped duties and the sync slow-down factor.
	logic [DUTY_W-1:0]     lduty_s3, rduty_s3;
	logic [FACT_W-1:0]     factor_s3;
	logic                  sync_s3, gap_pos_s3, up_s3;
	status_t               st_s3;
	logic [TICK_WIDTH-1:0] tick_s3;

	always_ff @(posedge clk) begin
		if (cmd.step_s3) begin
			lduty_s3   <= ldone_s2 ? '0 : clamp_duty(lprod_s2[PROD_W-1:PROP_SHIFT],
				cfg.min_duty, cfg.max_duty);
			rduty_s3   <= rdone_s2 ? '0 : clamp_duty(rprod_s2[PROD_W-1:PROP_SHIFT],
				cfg.min_duty, cfg.max_duty);
			factor_s3  <= (corr_s2 >= SYNC_ONE) ? '0 : FACT_W'(SYNC_ONE - corr_s2);
			sync_s3    <= sync_s2;
			gap_pos_s3 <= gap_pos_s2;
			up_s3      <= up_s2;
			st_s3      <= st_s2;
			tick_s3    <= tick_s2;
		end
	end

	// Final step: slowed duty, side selection, direction and result register.
	logic [SLOW_W-1:0] slow_prod;
	logic [DUTY_W-1:0] slow, lsel, rsel;
	logic [OUT_W-1:0]  lext, rext, lout, rout;
	logic              moving;

	assign slow_prod = SLOW_W'(cfg.max_duty) * SLOW_W'(factor_s3);
	assign slow      = slow_prod[SYNC_FRAC+DUTY_W-1:SYNC_FRAC];
	assign moving    = (st_s3 == ST_MOVING);
	assign lsel      = (sync_s3 && !gap_pos_s3) ? slow : lduty_s3;
	assign rsel      = (sync_s3 && gap_pos_s3) ? slow : rduty_s3;
	assign lext      = moving ? OUT_W'(lsel) : '0;
	assign rext      = moving ? OUT_W'(rsel) : '0;
	assign lout      = up_s3 ? lext : OUT_W'(0) - lext;
	assign rout      = up_s3 ? rext : OUT_W'(0) - rext;

	logic [OUT_W-1:0] left_duty_q, right_duty_q;
	status_t          status_q;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			left_duty_q  <= lout;
			right_duty_q <= rout;
			status_q     <= st_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			tick_q   <= '0;
		end else if (cmd.commit) begin
			active_q <= moving;
			if (moving && !(&tick_s3)) begin
				tick_q <= tick_s3 + 1'b1;
			end else begin
				tick_q <= tick_s3;
			end
		end
	end

	assign left_duty  = left_duty_q;
	assign right_duty = right_duty_q;
	assign status     = status_q;

endmodule

`default_nettype wire

/* rtl/core/synced_dual_actuator_position_ctrl.sv */
// Top level of the synchronised dual actuator position controller.
// An accepted input runs through the s1, s2 and s3 registers into the result register.
// One transaction at a time: a new one is accepted after the last is committed; the four
// steps of the shared datapath are errors, gain products, clamps and slowed-duty product;
// a stalled, full result register holds the next item in its last step.
// Reset: asynchronous; clears the move state and tick count, loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module synced_dual_actuator_position_ctrl (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic signed [sdapc_pkg::POS_WIDTH-1:0]    left_pos,
	input  logic signed [sdapc_pkg::POS_WIDTH-1:0]    right_pos,
	input  logic                                      cancel,
	input  logic                                      start_req,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic signed [sdapc_pkg::OUT_W-1:0]        left_duty,
	output logic signed [sdapc_pkg::OUT_W-1:0]        right_duty,
	output logic [sdapc_pkg::STATUS_W-1:0]            status,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [sdapc_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [sdapc_pkg::CFG_DATA_W-1:0]          cfg_data
);
	import sdapc_pkg::*;

	cfg_t      cfg;
	ctrl_cmd_t cmd;

	assign cfg_ready = 1'b1;

	sdapc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sdapc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	sdapc_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.left_pos   (left_pos),
		.right_pos  (right_pos),
		.cancel     (cancel),
		.start_req  (start_req),
		.left_duty  (left_duty),
		.right_duty (right_duty),
		.status     (status)
	);

endmodule

`default_nettype wire

/* rtl/core/sdapc_checker.sv */
// Port-level assertion checker for the position controller, with its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "synced_dual_actuator_position_ctrl_assert.svh"

module sdapc_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic                                   in_stall,
	input  logic                                   out_valid,
	input  logic                                   out_stall,
	input  logic signed [sdapc_pkg::OUT_W-1:0]     left_duty,
	input  logic signed [sdapc_pkg::OUT_W-1:0]     right_duty,
	input  logic [sdapc_pkg::STATUS_W-1:0]         status
);
	import sdapc_pkg::*;

	// A stalled result transaction keeps its payload.
	`SDAPC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(left_duty) && $stable(right_duty) && $stable(status), "stalled result changed")

	// One item at a time: an accepted input transaction makes the block busy.
	`SDAPC_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input accepted while busy")

	// Only a moving result carries a drive.
	`SDAPC_ASSERT_IMP(a_zero_when_stopped, out_valid && status != ST_MOVING, left_duty == '0 && right_duty == '0, "drive on a stopped result")

	// Both drives share the left side's direction.
	`SDAPC_ASSERT_IMP(a_same_direction, out_valid && left_duty != '0 && right_duty != '0, left_duty[OUT_W-1] == right_duty[OUT_W-1], "drives point opposite ways")

endmodule

bind synced_dual_actuator_position_ctrl sdapc_checker u_sdapc_checker (.*);

`default_nettype wire
